@@ hw/rtl/sldm_pkg.sv @@
// shared types and constants for the sliding window median filter
// no dependencies; every other file of the block uses this package
package sldm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 5'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FIN
  } state_t;

  // position qualifiers handed to the rank step unit
  typedef struct packed {
    logic in_window;
    logic earlier;
  } cmp_ctl_t;

endpackage

@@ hw/rtl/sldm_sample_if.sv @@
// input channel: valid/ready handshake carrying one sensor sample
// depends on sldm_pkg
interface sldm_sample_if;
  logic             valid;
  logic             ready;
  sldm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/sldm_median_if.sv @@
// result channel: valid/ready handshake carrying one median value
// depends on sldm_pkg
interface sldm_median_if;
  logic             valid;
  logic             ready;
  sldm_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

@@ hw/rtl/sldm_rank_step.sv @@
// shared compare unit: one signed compare of a window entry against the candidate
// and the rank count update; depends on sldm_pkg
module sldm_rank_step #(
  parameter int CNT_W = 5
) (
  input  sldm_pkg::sample_t  head,
  input  sldm_pkg::sample_t  cand,
  input  sldm_pkg::cmp_ctl_t ctl,
  input  logic [CNT_W-1:0]   rank_in,
  output logic [CNT_W-1:0]   rank_out
);

  logic below;

  // stable order: equal entries that sit earlier rank below the candidate
  assign below = ctl.in_window && ((head < cand) || ((head == cand) && ctl.earlier));
  assign rank_out = rank_in + CNT_W'(below);

endmodule

@@ hw/rtl/sliding_window_median_filter.sv @@
// sliding window median filter: for each input transaction, candidates are tried in
// turn (1..len of them), each loaded and then ranked against every window entry; the
// next transaction is taken once the result is posted, later while a finished result
// still waits on out_ch.ready; one shared compare unit takes one window entry per cycle,
// one sample in flight
// synchronous active-low reset: window cleared to zeros, window_len back to 5
module sliding_window_median_filter #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [sldm_pkg::CFG_W-1:0] cfg_wr_data,
  sldm_sample_if.sink                in_ch,
  sldm_median_if.source              out_ch
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_WINDOW);

  // configuration
  logic [sldm_pkg::CFG_W-1:0] win_len_r;

  // window: entry MAX_WINDOW-1 is the newest sample; rotates left during a scan
  sldm_pkg::sample_t window_r   [MAX_WINDOW];
  sldm_pkg::sample_t window_nxt [MAX_WINDOW];

  // sequencer
  sldm_pkg::state_t  state_r, state_nxt;
  sldm_pkg::sample_t cand_r, cand_nxt;
  logic [IDX_W-1:0]  cand_pos_r, cand_pos_nxt;
  logic [IDX_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  sldm_pkg::sample_t out_median_r, out_median_nxt;

  // derived window geometry
  logic [CNT_W-1:0]   eff_len;
  logic [CNT_W-1:0]   half_rank;
  logic [IDX_W-1:0]   first_pos;
  logic [CNT_W-1:0]   rank_step;
  sldm_pkg::cmp_ctl_t cmp_ctl;
  logic               in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == sldm_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.median = out_median_r;

  // zero length acts as one, long lengths saturate to the window depth
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(win_len_r) > MAX_WINDOW) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = CNT_W'(win_len_r);
    end
  end

  assign first_pos = IDX_W'(MAX_LEN - eff_len);
  assign half_rank = eff_len >> 1;

  // the head of the rotating window is the entry at scan_pos_r
  assign cmp_ctl.in_window = (scan_pos_r >= first_pos);
  assign cmp_ctl.earlier   = (scan_pos_r < cand_pos_r);

  sldm_rank_step #(
    .CNT_W (CNT_W)
  ) u_rank_step (
    .head     (window_r[0]),
    .cand     (cand_r),
    .ctl      (cmp_ctl),
    .rank_in  (rank_r),
    .rank_out (rank_step)
  );

  // window: shift in on a transaction, rotate by one while scanning
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      window_nxt[k] = window_r[k];
    end
    if (in_acc || (state_r == sldm_pkg::ST_SCAN)) begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
        window_nxt[k] = window_r[k + 1];
      end
      window_nxt[MAX_WINDOW - 1] = in_acc ? in_ch.sample : window_r[0];
    end
  end

  // sequencer: each candidate is loaded, then ranked against all entries
  always_comb begin
    state_nxt      = state_r;
    cand_nxt       = cand_r;
    cand_pos_nxt   = cand_pos_r;
    scan_pos_nxt   = scan_pos_r;
    rank_nxt       = rank_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_median_nxt = out_median_r;
    case (state_r)
      sldm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cand_pos_nxt = first_pos;
          state_nxt    = sldm_pkg::ST_LOAD;
        end
      end
      sldm_pkg::ST_LOAD: begin
        // window is in its home orientation here
        cand_nxt     = window_r[cand_pos_r];
        scan_pos_nxt = '0;
        rank_nxt     = '0;
        state_nxt    = sldm_pkg::ST_SCAN;
      end
      sldm_pkg::ST_SCAN: begin
        scan_pos_nxt = IDX_W'(scan_pos_r + 1'b1);
        rank_nxt     = rank_step;
        if (scan_pos_r == LAST_POS) begin
          // ranks form a permutation, so exactly one candidate hits the middle
          if (rank_step == half_rank) begin
            state_nxt = sldm_pkg::ST_FIN;
          end else begin
            cand_pos_nxt = IDX_W'(cand_pos_r + 1'b1);
            state_nxt    = sldm_pkg::ST_LOAD;
          end
        end
      end
      sldm_pkg::ST_FIN: begin
        // wait here until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = cand_r;
          state_nxt      = sldm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sldm_pkg::ST_IDLE;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sldm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      win_len_r   <= sldm_pkg::CFG_LEN_RESET;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        window_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_len_r <= cfg_wr_data;
      end
      for (int k = 0; k < MAX_WINDOW; k++) begin
        window_r[k] <= window_nxt[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    cand_pos_r   <= cand_pos_nxt;
    scan_pos_r   <= scan_pos_nxt;
    rank_r       <= rank_nxt;
    out_median_r <= out_median_nxt;
  end

endmodule

@@ hw/rtl/sldm_checker.sv @@
// port-level checks for the sliding window median filter, bound to the top level
// depends on sliding_window_median_filter and sldm_pkg
module sldm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sldm_pkg::sample_t out_median
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_median)))
    else $error("result changed while stalled");

  // the block is busy for at least the load and first compare after a transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready))
    else $error("input taken again while busy");

  // a new result only shows up at the end of work, never from idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // a result posting returns the block to idle
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("not ready after result");

endmodule

bind sliding_window_median_filter sldm_checker u_sldm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_median (out_ch.median)
);
